>>> rtl/core/sfk_pkg.sv
// shared types, constants and crc function for the sync frame timestamp keeper
package sfk_pkg;

   localparam int unsigned OpWidth      = 2;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned VerdictWidth = 2;
   localparam int unsigned CountWidth   = 16;
   localparam int unsigned StampWidth   = 64;
   localparam int unsigned CsrWidth     = 16;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned PosWidth     = 4;

   localparam logic [PosWidth-1:0] FrameLen = 4'd12;
   localparam logic [PosWidth-1:0] CrcCover = 4'd10;
   localparam logic [PosWidth-1:0] CountLen = 4'd2;

   localparam logic [CsrWidth-1:0] CrcPolyReset  = 16'h1021;
   localparam logic [CsrWidth-1:0] CrcInitReset  = 16'h0000;
   localparam logic [CsrWidth-1:0] TickDivReset  = 16'd5;

   typedef enum logic [OpWidth-1:0] {
      OpFrameByte = 2'd0,
      OpTick      = 2'd1,
      OpEdge      = 2'd2
   } op_type;

   typedef enum logic [VerdictWidth-1:0] {
      VerdictAccepted    = 2'd0,
      VerdictCrcMismatch = 2'd1,
      VerdictTooShort    = 2'd2
   } verdict_type;

   typedef enum logic {
      KindVerdict = 1'b0,
      KindEdge    = 1'b1
   } kind_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CsrCrcPoly     = 2'd0,
      CsrCrcInit     = 2'd1,
      CsrTickDivisor = 2'd2
   } csr_index_type;

   // msb-first crc over one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/sfk_req_if.sv
// request channel: operation, byte and end mark with valid/ready
interface sfk_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sfk_pkg::OpWidth-1:0]          operation;
   logic [sfk_pkg::ByteWidth-1:0]        data_byte;
   logic                                 frame_end;

   modport source (output valid, output operation, output data_byte, output frame_end,
                   input ready);
   modport sink   (input valid, input operation, input data_byte, input frame_end,
                   output ready);
endinterface

>>> rtl/core/sfk_rsp_if.sv
// result channel: verdict or edge timestamp with valid/ready
interface sfk_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 result_kind;
   logic [sfk_pkg::VerdictWidth-1:0]     verdict;
   logic [sfk_pkg::CountWidth-1:0]       message_count;
   logic [sfk_pkg::StampWidth-1:0]       timestamp;

   modport source (output valid, output result_kind, output verdict, output message_count,
                   output timestamp, input ready);
   modport sink   (input valid, input result_kind, input verdict, input message_count,
                   input timestamp, output ready);
endinterface

>>> rtl/core/sync_frame_timestamp_keeper.sv
// top level: crc-checked time sync frame receiver and edge timestamper
//
// usage:
//  - req_chan carries one request per handshake: a datagram byte (with frame_end
//    on the last byte), a one-microsecond tick, or a falling-edge event
//  - rsp_chan returns a verdict when a datagram ends and an edge timestamp for
//    each edge event; ticks give no response
//  - csr_write_en/csr_index/csr_write_data set crc_poly, crc_init and
//    tick_divisor; write only while the block is idle
//  - a request is taken into an input register, processed in one pass and its
//    response lands in the output register, which drives rsp_chan
//  - throughput is one request per cycle unless rsp_chan stalls, set by the
//    single-pass frame and time update between the input and output registers
//  - when rsp_chan stalls, the output register holds its response; requests
//    that give no response keep flowing, and a request that needs the output
//    waits in the input register, after which req_chan.ready drops
//  - synchronous reset empties both registers, restores the register defaults
//    and clears frame assembly, the latched stamp and local time
module sync_frame_timestamp_keeper (
   input  logic                              clock,
   input  logic                              reset,
   sfk_req_if.sink                           req_chan,
   sfk_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_en,
   input  logic [sfk_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [sfk_pkg::CsrWidth-1:0]      csr_write_data
);

   // configuration
   logic [15:0] crc_poly_ff, crc_init_ff, tick_div_ff;

   // input register
   logic                               in_valid_ff;
   sfk_pkg::op_type                    in_op_ff;
   logic [sfk_pkg::ByteWidth-1:0]      in_byte_ff;
   logic                               in_end_ff;

   // frame and time state
   logic [sfk_pkg::PosWidth-1:0]       byte_pos_ff, byte_pos_in;
   logic [15:0]                        crc_run_ff, crc_run_in;
   logic [15:0]                        pend_count_ff, pend_count_in;
   logic [63:0]                        pend_stamp_ff, pend_stamp_in;
   logic [15:0]                        rx_crc_ff, rx_crc_in;
   logic [15:0]                        latch_count_ff, latch_count_in;
   logic [63:0]                        latch_stamp_ff, latch_stamp_in;
   logic [15:0]                        phase_ff, phase_in;
   logic [63:0]                        elapsed_ff, elapsed_in;

   // output register
   logic                               out_valid_ff, out_valid_in;
   sfk_pkg::kind_type                  out_kind_ff, out_kind_in;
   sfk_pkg::verdict_type               out_verdict_ff, out_verdict_in;
   logic [15:0]                        out_count_ff, out_count_in;
   logic [63:0]                        out_stamp_ff, out_stamp_in;

   logic        has_rsp, go;
   logic [15:0] crc_base, div_eff;
   logic [16:0] phase_inc;

   assign has_rsp = (in_op_ff == sfk_pkg::OpEdge) ||
                    ((in_op_ff == sfk_pkg::OpFrameByte) && in_end_ff);
   assign go      = in_valid_ff && (!has_rsp || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || go;

   assign crc_base  = (byte_pos_ff == '0) ? crc_init_ff : crc_run_ff;
   assign div_eff   = (tick_div_ff == '0) ? 16'd1 : tick_div_ff;
   assign phase_inc = {1'b0, phase_ff} + 17'd1;

   always_comb begin
      byte_pos_in    = byte_pos_ff;
      crc_run_in     = crc_run_ff;
      pend_count_in  = pend_count_ff;
      pend_stamp_in  = pend_stamp_ff;
      rx_crc_in      = rx_crc_ff;
      latch_count_in = latch_count_ff;
      latch_stamp_in = latch_stamp_ff;
      phase_in       = phase_ff;
      elapsed_in     = elapsed_ff;
      out_kind_in    = out_kind_ff;
      out_verdict_in = out_verdict_ff;
      out_count_in   = out_count_ff;
      out_stamp_in   = out_stamp_ff;

      if (go) begin
         case (in_op_ff)
            sfk_pkg::OpFrameByte: begin
               if (byte_pos_ff < sfk_pkg::FrameLen) begin
                  if (byte_pos_ff < sfk_pkg::CrcCover) begin
                     crc_run_in = sfk_pkg::crc_byte(crc_base, in_byte_ff, crc_poly_ff);
                  end
                  if (byte_pos_ff == '0) begin
                     pend_count_in = {8'h00, in_byte_ff};
                     pend_stamp_in = '0;
                     rx_crc_in     = '0;
                  end else if (byte_pos_ff < sfk_pkg::CountLen) begin
                     pend_count_in = pend_count_ff | {in_byte_ff, 8'h00};
                  end else if (byte_pos_ff < sfk_pkg::CrcCover) begin
                     for (int k = 0; k < 8; k++) begin
                        if (byte_pos_ff == 4'(k + 2)) begin
                           pend_stamp_in[8*k +: 8] = pend_stamp_ff[8*k +: 8] | in_byte_ff;
                        end
                     end
                  end else begin
                     rx_crc_in = {rx_crc_ff[7:0], in_byte_ff};
                  end
                  byte_pos_in = byte_pos_ff + 4'd1;
               end
               if (in_end_ff) begin
                  if (byte_pos_in < sfk_pkg::FrameLen) begin
                     out_verdict_in = sfk_pkg::VerdictTooShort;
                  end else if (rx_crc_in == crc_run_in) begin
                     out_verdict_in = sfk_pkg::VerdictAccepted;
                     latch_count_in = pend_count_in;
                     latch_stamp_in = pend_stamp_in;
                     phase_in       = '0;
                     elapsed_in     = '0;
                  end else begin
                     out_verdict_in = sfk_pkg::VerdictCrcMismatch;
                  end
                  byte_pos_in  = '0;
                  crc_run_in   = crc_init_ff;
                  out_kind_in  = sfk_pkg::KindVerdict;
                  out_count_in = latch_count_in;
                  out_stamp_in = latch_stamp_in;
               end
            end
            sfk_pkg::OpTick: begin
               if (phase_inc >= {1'b0, div_eff}) begin
                  phase_in = '0;
                  if (elapsed_ff != '1) begin
                     elapsed_in = elapsed_ff + 64'd1;
                  end
               end else begin
                  phase_in = phase_inc[15:0];
               end
            end
            sfk_pkg::OpEdge: begin
               out_kind_in    = sfk_pkg::KindEdge;
               out_verdict_in = sfk_pkg::VerdictAccepted;
               out_count_in   = latch_count_ff;
               out_stamp_in   = latch_stamp_ff + elapsed_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign out_valid_in = (go && has_rsp) || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff    <= sfk_pkg::CrcPolyReset;
         crc_init_ff    <= sfk_pkg::CrcInitReset;
         tick_div_ff    <= sfk_pkg::TickDivReset;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         byte_pos_ff    <= '0;
         crc_run_ff     <= sfk_pkg::CrcInitReset;
         pend_count_ff  <= '0;
         pend_stamp_ff  <= '0;
         rx_crc_ff      <= '0;
         latch_count_ff <= '0;
         latch_stamp_ff <= '0;
         phase_ff       <= '0;
         elapsed_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            case (sfk_pkg::csr_index_type'(csr_index))
               sfk_pkg::CsrCrcPoly:     crc_poly_ff <= csr_write_data;
               sfk_pkg::CsrCrcInit:     crc_init_ff <= csr_write_data;
               sfk_pkg::CsrTickDivisor: tick_div_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         out_valid_ff   <= out_valid_in;
         byte_pos_ff    <= byte_pos_in;
         crc_run_ff     <= crc_run_in;
         pend_count_ff  <= pend_count_in;
         pend_stamp_ff  <= pend_stamp_in;
         rx_crc_ff      <= rx_crc_in;
         latch_count_ff <= latch_count_in;
         latch_stamp_ff <= latch_stamp_in;
         phase_ff       <= phase_in;
         elapsed_ff     <= elapsed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_op_ff   <= sfk_pkg::op_type'(req_chan.operation);
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.frame_end;
      end
      out_kind_ff    <= out_kind_in;
      out_verdict_ff <= out_verdict_in;
      out_count_ff   <= out_count_in;
      out_stamp_ff   <= out_stamp_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_kind_ff;
   assign rsp_chan.verdict       = out_verdict_ff;
   assign rsp_chan.message_count = out_count_ff;
   assign rsp_chan.timestamp     = out_stamp_ff;

`ifndef SYNTH
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      byte_pos_ff <= sfk_pkg::FrameLen)
      else $error("byte position past frame length");

   a_edge_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == sfk_pkg::KindEdge) |->
         out_verdict_ff == sfk_pkg::VerdictAccepted)
      else $error("edge response with nonzero verdict");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && has_rsp && out_valid_ff && !rsp_chan.ready) |-> !go)
      else $error("response request advanced into a full output register");
`endif

endmodule
